/* sv/bpa_pkg.sv */
// Shared types and constants for the bitmap page allocator.
package bpa_pkg;

    localparam int DEF_BITMAP_WORDS      = 1024;
    localparam int DEF_RECORDS           = 64;
    localparam int CFG_W                 = 11;
    localparam int WORD_BITS             = 32;
    localparam int SEG_BITS              = 8;
    localparam int SEGS                  = WORD_BITS / SEG_BITS;
    localparam int SEG_IDX_W             = $clog2(SEGS);
    localparam int SEG_POS_W             = $clog2(SEG_BITS);
    localparam int RUN_W                 = 17;
    localparam int COUNT_W               = 16;
    localparam int FBASE_W               = 15;
    localparam int RESET_USED_WORDS      = 1024;
    localparam int RESET_KERNEL_WORDS    = 16;
    localparam int KERNEL_RESERVED_WORDS = 8;
    localparam int KERNEL_PAGES          = 256;

    typedef enum logic [1:0] {
        CFG_USED_WORDS   = 2'd0,
        CFG_KERNEL_WORDS = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        RES_OK         = 3'd0,
        RES_NO_RUN     = 3'd1,
        RES_TABLE_FULL = 3'd2,
        RES_NOT_ALLOC  = 3'd3,
        RES_ZERO_COUNT = 3'd4
    } res_code_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACHK,
        S_SRD,
        S_SSCAN,
        S_FOUND,
        S_MINIT,
        S_MRD,
        S_MWR,
        S_RECWR,
        S_FSTART,
        S_FRD,
        S_FCMP,
        S_SHCHK,
        S_SHWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic      clear_step;
        logic      load_item;
        logic      scan_init;
        logic      scan_read;
        logic      scan_step;
        logic      word_next;
        logic      mod_init;
        logic      mod_read;
        logic      mod_write;
        logic      rec_append;
        logic      rec_init;
        logic      rec_read;
        logic      rec_next;
        logic      rec_take;
        logic      shift_read;
        logic      shift_write;
        logic      fill_dec;
        logic      code_we;
        res_code_t code;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic zero_count;
        logic area_empty;
        logic seg_found;
        logic seg_last;
        logic word_last;
        logic table_full;
        logic mod_last;
        logic fill_empty;
        logic rec_match;
        logic rec_last;
        logic out_busy;
    } stat_t;

endpackage

/* sv/bitmap_page_allocator.sv */
// Top level of the bitmap page allocator.
// Allocate: an area check, a scan of each bitmap word segment by segment, then a read and write of each word updated.
// Free: a search of the record table, a read and write of each word cleared, then the later records shifted down.
// One request at a time; the bitmap sits in single-port memory.
// After reset a clearing pass writes each of the BITMAP_WORDS bitmap words before s_ready rises.
// Configuration writes are taken in every cycle.
module bitmap_page_allocator #(
    parameter int BITMAP_WORDS = bpa_pkg::DEF_BITMAP_WORDS,
    parameter int RECORDS      = bpa_pkg::DEF_RECORDS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic                        s_kernel_area,
    input  logic [bpa_pkg::COUNT_W-1:0] s_page_count,
    input  logic [bpa_pkg::FBASE_W-1:0] s_free_base_page,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_status,
    output logic [bpa_pkg::FBASE_W-1:0] m_base_page,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]   cfg_data
);

    bpa_pkg::cmd_t  cmd;
    bpa_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bpa_datapath #(
        .BITMAP_WORDS (BITMAP_WORDS),
        .RECORDS      (RECORDS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_op             (s_op),
        .s_kernel_area    (s_kernel_area),
        .s_page_count     (s_page_count),
        .s_free_base_page (s_free_base_page),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_base_page      (m_base_page)
    );

endmodule

/* sv/bpa_ctrl.sv */
// Controller state machine for the bitmap page allocator.
module bpa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bpa_pkg::stat_t stat,
    output bpa_pkg::cmd_t  cmd
);

    bpa_pkg::state_t state_reg;
    bpa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpa_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::S_CLEAR: begin
                if (stat.clear_last) state_next = bpa_pkg::S_IDLE;
            end
            bpa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = stat.is_free ? bpa_pkg::S_FSTART : bpa_pkg::S_ACHK;
                end
            end
            bpa_pkg::S_ACHK: begin
                if (stat.zero_count || stat.area_empty) state_next = bpa_pkg::S_DONE;
                else state_next = bpa_pkg::S_SRD;
            end
            bpa_pkg::S_SRD: state_next = bpa_pkg::S_SSCAN;
            bpa_pkg::S_SSCAN: begin
                if (stat.seg_found) state_next = bpa_pkg::S_FOUND;
                else if (stat.seg_last) begin
                    state_next = stat.word_last ? bpa_pkg::S_DONE : bpa_pkg::S_SRD;
                end
            end
            bpa_pkg::S_FOUND: begin
                state_next = stat.table_full ? bpa_pkg::S_DONE : bpa_pkg::S_MINIT;
            end
            bpa_pkg::S_MINIT: state_next = bpa_pkg::S_MRD;
            bpa_pkg::S_MRD:   state_next = bpa_pkg::S_MWR;
            bpa_pkg::S_MWR: begin
                if (stat.mod_last) begin
                    state_next = stat.is_free ? bpa_pkg::S_SHCHK : bpa_pkg::S_RECWR;
                end else begin
                    state_next = bpa_pkg::S_MRD;
                end
            end
            bpa_pkg::S_RECWR: state_next = bpa_pkg::S_DONE;
            bpa_pkg::S_FSTART: begin
                state_next = stat.fill_empty ? bpa_pkg::S_DONE : bpa_pkg::S_FRD;
            end
            bpa_pkg::S_FRD: state_next = bpa_pkg::S_FCMP;
            bpa_pkg::S_FCMP: begin
                if (stat.rec_match) state_next = bpa_pkg::S_MINIT;
                else if (stat.rec_last) state_next = bpa_pkg::S_DONE;
                else state_next = bpa_pkg::S_FRD;
            end
            bpa_pkg::S_SHCHK: begin
                state_next = stat.rec_last ? bpa_pkg::S_DONE : bpa_pkg::S_SHWR;
            end
            bpa_pkg::S_SHWR: state_next = bpa_pkg::S_SHCHK;
            bpa_pkg::S_DONE: begin
                if (!stat.out_busy) state_next = bpa_pkg::S_IDLE;
            end
            default: state_next = bpa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.code = bpa_pkg::RES_OK;
        s_ready  = 1'b0;
        case (state_reg)
            bpa_pkg::S_CLEAR: cmd.clear_step = 1'b1;
            bpa_pkg::S_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            bpa_pkg::S_ACHK: begin
                cmd.scan_init = 1'b1;
                if (stat.zero_count) begin
                    cmd.code_we = 1'b1;
                    cmd.code    = bpa_pkg::RES_ZERO_COUNT;
                end else if (stat.area_empty) begin
                    cmd.code_we = 1'b1;
                    cmd.code    = bpa_pkg::RES_NO_RUN;
                end
            end
            bpa_pkg::S_SRD: cmd.scan_read = 1'b1;
            bpa_pkg::S_SSCAN: begin
                cmd.scan_step = 1'b1;
                if (!stat.seg_found && stat.seg_last) begin
                    cmd.word_next = 1'b1;
                    if (stat.word_last) begin
                        cmd.code_we = 1'b1;
                        cmd.code    = bpa_pkg::RES_NO_RUN;
                    end
                end
            end
            bpa_pkg::S_FOUND: begin
                if (stat.table_full) begin
                    cmd.code_we = 1'b1;
                    cmd.code    = bpa_pkg::RES_TABLE_FULL;
                end
            end
            bpa_pkg::S_MINIT: cmd.mod_init  = 1'b1;
            bpa_pkg::S_MRD:   cmd.mod_read  = 1'b1;
            bpa_pkg::S_MWR:   cmd.mod_write = 1'b1;
            bpa_pkg::S_RECWR: begin
                cmd.rec_append = 1'b1;
                cmd.code_we    = 1'b1;
                cmd.code       = bpa_pkg::RES_OK;
            end
            bpa_pkg::S_FSTART: begin
                cmd.rec_init = 1'b1;
                if (stat.fill_empty) begin
                    cmd.code_we = 1'b1;
                    cmd.code    = bpa_pkg::RES_NOT_ALLOC;
                end
            end
            bpa_pkg::S_FRD: cmd.rec_read = 1'b1;
            bpa_pkg::S_FCMP: begin
                if (stat.rec_match) begin
                    cmd.rec_take = 1'b1;
                end else if (stat.rec_last) begin
                    cmd.code_we = 1'b1;
                    cmd.code    = bpa_pkg::RES_NOT_ALLOC;
                end else begin
                    cmd.rec_next = 1'b1;
                end
            end
            bpa_pkg::S_SHCHK: begin
                if (stat.rec_last) begin
                    cmd.fill_dec = 1'b1;
                    cmd.code_we  = 1'b1;
                    cmd.code     = bpa_pkg::RES_OK;
                end else begin
                    cmd.shift_read = 1'b1;
                end
            end
            bpa_pkg::S_SHWR: cmd.shift_write = 1'b1;
            bpa_pkg::S_DONE: cmd.out_load = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

/* sv/bpa_datapath.sv */
// Datapath of the bitmap page allocator: bitmap, record table, scan and update logic.
module bpa_datapath #(
    parameter int BITMAP_WORDS = bpa_pkg::DEF_BITMAP_WORDS,
    parameter int RECORDS      = bpa_pkg::DEF_RECORDS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bpa_pkg::cmd_t               cmd,
    output bpa_pkg::stat_t              stat,
    input  logic                        s_op,
    input  logic                        s_kernel_area,
    input  logic [bpa_pkg::COUNT_W-1:0] s_page_count,
    input  logic [bpa_pkg::FBASE_W-1:0] s_free_base_page,
    input  logic                        cfg_valid,
    input  logic [1:0]                  cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]   cfg_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [2:0]                  m_status,
    output logic [bpa_pkg::FBASE_W-1:0] m_base_page
);

    localparam int WORD_W = $clog2(BITMAP_WORDS);
    localparam int WCNT_W = WORD_W + 1;
    localparam int PAGE_W = WORD_W + 5;
    localparam int REC_W  = $clog2(RECORDS);
    localparam int FILL_W = $clog2(RECORDS + 1);
    localparam int CW     = (WCNT_W > bpa_pkg::CFG_W) ? WCNT_W : bpa_pkg::CFG_W;
    localparam int BW     = (PAGE_W > bpa_pkg::FBASE_W) ? PAGE_W : bpa_pkg::FBASE_W;

    logic [bpa_pkg::WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
    logic [PAGE_W-1:0]             rec_base_mem [RECORDS];
    logic [bpa_pkg::COUNT_W-1:0]   rec_count_mem [RECORDS];

    logic [bpa_pkg::CFG_W-1:0]     used_words_reg;
    logic [bpa_pkg::CFG_W-1:0]     kernel_words_reg;
    logic [WCNT_W-1:0]             clr_cnt_reg;
    logic [FILL_W-1:0]             fill_reg;
    logic                          m_valid_reg;
    logic [2:0]                    m_status_reg;
    logic [bpa_pkg::FBASE_W-1:0]   m_base_reg;

    logic                          op_reg;
    logic                          kern_reg;
    logic [bpa_pkg::COUNT_W-1:0]   num_reg;
    logic [bpa_pkg::FBASE_W-1:0]   fbase_reg;
    logic [WCNT_W-1:0]             word_reg;
    logic [WCNT_W-1:0]             end_reg;
    logic [bpa_pkg::SEG_IDX_W-1:0] seg_reg;
    logic [bpa_pkg::COUNT_W-1:0]   run_reg;
    logic [PAGE_W-1:0]             base_reg;
    logic [WORD_W-1:0]             mod_word_reg;
    logic [REC_W-1:0]              k_reg;
    bpa_pkg::res_code_t            code_reg;
    logic [bpa_pkg::WORD_BITS-1:0] bm_rdata_reg;
    logic [PAGE_W-1:0]             rec_base_rdata_reg;
    logic [bpa_pkg::COUNT_W-1:0]   rec_count_rdata_reg;

    logic [CW-1:0]                 kw_ext;
    logic [CW-1:0]                 uw_ext;
    logic [WCNT_W-1:0]             kw_c;
    logic [WCNT_W-1:0]             uw_c;
    logic [WCNT_W-1:0]             start_w;
    logic [WCNT_W-1:0]             end_w;

    logic [bpa_pkg::SEG_BITS-1:0]  seg_bits;
    logic                          any_used;
    logic [bpa_pkg::SEG_POS_W-1:0] last_used;
    logic [bpa_pkg::RUN_W-1:0]     run_j;
    logic                          seg_found;
    logic [bpa_pkg::SEG_POS_W-1:0] seg_pos;
    logic [PAGE_W-1:0]             hit_page;
    logic [31:0]                   base_sum;

    logic [31:0]                   last_sum;
    logic [PAGE_W-1:0]             last_page;
    logic [WORD_W-1:0]             first_word;
    logic [WORD_W-1:0]             last_word;
    logic [4:0]                    lo_bit;
    logic [4:0]                    hi_bit;
    logic [bpa_pkg::WORD_BITS-1:0] mod_mask;
    logic [bpa_pkg::WORD_BITS-1:0] mod_wdata;

    logic [FILL_W-1:0]             k_plus;
    logic [REC_W-1:0]              rec_raddr;
    logic [BW-1:0]                 rec_base_cmp;
    logic [BW-1:0]                 fbase_cmp;

    assign kw_ext  = CW'(kernel_words_reg);
    assign uw_ext  = CW'(used_words_reg);
    assign kw_c    = (kw_ext > CW'(BITMAP_WORDS)) ? WCNT_W'(BITMAP_WORDS) : WCNT_W'(kw_ext);
    assign uw_c    = (uw_ext > CW'(BITMAP_WORDS)) ? WCNT_W'(BITMAP_WORDS) : WCNT_W'(uw_ext);
    assign start_w = kern_reg ? '0 : kw_c;
    assign end_w   = kern_reg ? kw_c : uw_c;

    assign seg_bits = bm_rdata_reg[seg_reg * bpa_pkg::SEG_BITS +: bpa_pkg::SEG_BITS];

    always_comb begin
        any_used  = 1'b0;
        last_used = '0;
        run_j     = '0;
        seg_found = 1'b0;
        seg_pos   = '0;
        for (int j = 0; j < bpa_pkg::SEG_BITS; j++) begin
            if (seg_bits[j]) begin
                any_used  = 1'b1;
                last_used = bpa_pkg::SEG_POS_W'(j);
                run_j     = '0;
            end else if (any_used) begin
                run_j = bpa_pkg::RUN_W'(bpa_pkg::SEG_POS_W'(j) - last_used);
            end else begin
                run_j = bpa_pkg::RUN_W'(run_reg) + bpa_pkg::RUN_W'(j + 1);
            end
            if (!seg_bits[j] && (run_j >= bpa_pkg::RUN_W'(num_reg)) && !seg_found) begin
                seg_found = 1'b1;
                seg_pos   = bpa_pkg::SEG_POS_W'(j);
            end
        end
    end

    assign hit_page = {word_reg[WORD_W-1:0], seg_reg, seg_pos};
    assign base_sum = 32'(hit_page) + 32'd1 - 32'(num_reg);

    assign last_sum   = 32'(base_reg) + 32'(num_reg) - 32'd1;
    assign last_page  = PAGE_W'(last_sum);
    assign first_word = base_reg[PAGE_W-1:5];
    assign last_word  = last_page[PAGE_W-1:5];
    assign lo_bit     = (mod_word_reg == first_word) ? base_reg[4:0] : 5'd0;
    assign hi_bit     = (mod_word_reg == last_word) ? last_page[4:0] : 5'd31;
    assign mod_mask   = ({bpa_pkg::WORD_BITS{1'b1}} << lo_bit)
                      & ({bpa_pkg::WORD_BITS{1'b1}} >> (5'd31 - hi_bit));
    assign mod_wdata  = op_reg ? (bm_rdata_reg & ~mod_mask) : (bm_rdata_reg | mod_mask);

    assign k_plus       = FILL_W'(k_reg) + FILL_W'(1);
    assign rec_raddr    = cmd.shift_read ? k_plus[REC_W-1:0] : k_reg;
    assign rec_base_cmp = BW'(rec_base_rdata_reg);
    assign fbase_cmp    = BW'(fbase_reg);

    always_comb begin
        stat            = '0;
        stat.clear_last = (clr_cnt_reg == WCNT_W'(BITMAP_WORDS - 1));
        stat.is_free    = cmd.load_item ? s_op : op_reg;
        stat.zero_count = (num_reg == '0);
        stat.area_empty = (start_w >= end_w);
        stat.seg_found  = seg_found;
        stat.seg_last   = (seg_reg == bpa_pkg::SEG_IDX_W'(bpa_pkg::SEGS - 1));
        stat.word_last  = ((word_reg + WCNT_W'(1)) == end_reg);
        stat.table_full = (fill_reg >= FILL_W'(RECORDS));
        stat.mod_last   = (mod_word_reg == last_word);
        stat.fill_empty = (fill_reg == '0);
        stat.rec_match  = (rec_base_cmp == fbase_cmp);
        stat.rec_last   = (k_plus >= fill_reg);
        stat.out_busy   = m_valid_reg && !m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_words_reg   <= bpa_pkg::CFG_W'(bpa_pkg::RESET_USED_WORDS);
            kernel_words_reg <= bpa_pkg::CFG_W'(bpa_pkg::RESET_KERNEL_WORDS);
            clr_cnt_reg      <= '0;
            fill_reg         <= FILL_W'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    bpa_pkg::CFG_USED_WORDS:   used_words_reg   <= cfg_data;
                    bpa_pkg::CFG_KERNEL_WORDS: kernel_words_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear_step) clr_cnt_reg <= clr_cnt_reg + WCNT_W'(1);
            if (cmd.rec_append) fill_reg <= fill_reg + FILL_W'(1);
            else if (cmd.fill_dec) fill_reg <= fill_reg - FILL_W'(1);
            if (cmd.out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_op;
            kern_reg  <= s_kernel_area;
            num_reg   <= s_page_count;
            fbase_reg <= s_free_base_page;
        end
        if (cmd.scan_init) begin
            word_reg <= start_w;
            end_reg  <= end_w;
            seg_reg  <= '0;
            run_reg  <= '0;
        end
        if (cmd.scan_step) begin
            run_reg <= bpa_pkg::COUNT_W'(run_j);
            seg_reg <= seg_reg + bpa_pkg::SEG_IDX_W'(1);
            if (seg_found) base_reg <= PAGE_W'(base_sum);
        end
        if (cmd.word_next) word_reg <= word_reg + WCNT_W'(1);
        if (cmd.mod_init) mod_word_reg <= first_word;
        if (cmd.mod_write) mod_word_reg <= mod_word_reg + WORD_W'(1);
        if (cmd.rec_init) k_reg <= '0;
        if (cmd.rec_next || cmd.shift_write) k_reg <= k_plus[REC_W-1:0];
        if (cmd.rec_take) begin
            base_reg <= PAGE_W'(fbase_reg);
            num_reg  <= rec_count_rdata_reg;
        end
        if (cmd.code_we) code_reg <= cmd.code;
        if (cmd.out_load) begin
            m_status_reg <= code_reg;
            m_base_reg   <= (!op_reg && code_reg == bpa_pkg::RES_OK)
                          ? bpa_pkg::FBASE_W'(base_reg) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            bitmap_mem[clr_cnt_reg[WORD_W-1:0]] <=
                (clr_cnt_reg < WCNT_W'(bpa_pkg::KERNEL_RESERVED_WORDS))
                ? {bpa_pkg::WORD_BITS{1'b1}} : '0;
        end else if (cmd.mod_write) begin
            bitmap_mem[mod_word_reg] <= mod_wdata;
        end
        if (cmd.scan_read) bm_rdata_reg <= bitmap_mem[word_reg[WORD_W-1:0]];
        else if (cmd.mod_read) bm_rdata_reg <= bitmap_mem[mod_word_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear_step && clr_cnt_reg == '0) begin
            rec_base_mem[0]  <= '0;
            rec_count_mem[0] <= bpa_pkg::COUNT_W'(bpa_pkg::KERNEL_PAGES);
        end else if (cmd.rec_append) begin
            rec_base_mem[fill_reg[REC_W-1:0]]  <= base_reg;
            rec_count_mem[fill_reg[REC_W-1:0]] <= num_reg;
        end else if (cmd.shift_write) begin
            rec_base_mem[k_reg]  <= rec_base_rdata_reg;
            rec_count_mem[k_reg] <= rec_count_rdata_reg;
        end
        if (cmd.rec_read || cmd.shift_read) begin
            rec_base_rdata_reg  <= rec_base_mem[rec_raddr];
            rec_count_rdata_reg <= rec_count_mem[rec_raddr];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_base_page = m_base_reg;

endmodule
